/* design/xsf_pkg.sv */
// ----------------------------------------------------------------------------
// xsf_pkg
// shared types and constants for the xor sprite framebuffer
// ----------------------------------------------------------------------------
package xsf_pkg;

   localparam int DISPLAY_WIDTH_DEF   = 64;
   localparam int DISPLAY_HEIGHT_DEF  = 32;
   localparam int MAX_SPRITE_ROWS_DEF = 16;

   localparam int SPRITE_BITS  = 8;
   localparam int ROW_PIXELS_W = 64;

   localparam logic [1:0] MODE_DRAW  = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]             mode;
      logic [7:0]             x_pos;
      logic [7:0]             y_pos;
      logic [3:0]             row_index;
      logic [SPRITE_BITS-1:0] sprite_byte;
      logic                   last_row;
   } req_type;

   typedef struct packed {
      logic                    collision;
      logic [ROW_PIXELS_W-1:0] row_pixels;
   } rsp_type;

endpackage

/* design/xsf_ram.sv */
// ----------------------------------------------------------------------------
// xsf_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module xsf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/xor_sprite_framebuffer.sv */
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer
// one-bit-per-pixel display store with xor sprite drawing and collision flag
// ----------------------------------------------------------------------------
// usage:
//   a command is taken on the rising edge where start is high and busy is
//   low. req_data.mode selects draw of one sprite row, clear of the display
//   or read of one display row.
//   every command returns exactly one result: rsp_strobe is high for one
//   cycle with rsp_data, on the cycle right after the transfer; busy is high
//   in that cycle, so no new command is taken then. a command first reads
//   one display row of the frame ram; a draw then writes the row back,
//   while busy is high.
//   collision is set only on a draw with last_row set; row_pixels only on a
//   read of a row inside the display. other fields are zero.
//   clear drops all the per-row valid bits together; a row that is not
//   valid reads as zero, so no clearing pass is needed.
//   reset clears the valid bits, the collision flag and the control state.
//   the receiver cannot stall: each result is on the ports for one cycle.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer import xsf_pkg::*; #(
   parameter int DISPLAY_WIDTH   = DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT  = DISPLAY_HEIGHT_DEF,
   parameter int MAX_SPRITE_ROWS = MAX_SPRITE_ROWS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int ROW_AW = (DISPLAY_HEIGHT > 1) ? $clog2(DISPLAY_HEIGHT) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                      state_ff, state_in;
   req_type                   req_ff;
   logic [ROW_AW-1:0]         addr_ff, addr_in;
   logic                      in_range_ff, in_range_in;
   logic [DISPLAY_HEIGHT-1:0] valid_ff, valid_in;
   logic                      seen_ff, seen_in;

   logic                      accept;
   logic                      exec;
   logic [8:0]                row_sum;
   logic                      draw_ok;
   logic                      read_ok;
   logic [SPRITE_BITS-1:0]    rev_bits;
   logic [DISPLAY_WIDTH-1:0]  mask;
   logic [DISPLAY_WIDTH-1:0]  rd_row;
   logic [DISPLAY_WIDTH-1:0]  old_row;
   logic                      hit;
   logic                      wr_en;

   assign busy   = (state_ff == ST_EXEC);
   assign exec   = (state_ff == ST_EXEC);
   assign accept = start && !busy;

   // address decode on the transfer
   assign row_sum = {1'b0, req_data.y_pos} + {5'b0, req_data.row_index};
   assign draw_ok = ({1'b0, req_data.row_index} < 5'(MAX_SPRITE_ROWS)) &&
                    (row_sum < 9'(DISPLAY_HEIGHT));
   assign read_ok = ({1'b0, req_data.y_pos} < 9'(DISPLAY_HEIGHT));

   always_comb begin
      unique case (req_data.mode)
         MODE_DRAW: begin
            addr_in     = row_sum[ROW_AW-1:0];
            in_range_in = draw_ok;
         end
         MODE_READ: begin
            addr_in     = req_data.y_pos[ROW_AW-1:0];
            in_range_in = read_ok;
         end
         default: begin
            addr_in     = row_sum[ROW_AW-1:0];
            in_range_in = 1'b0;
         end
      endcase
   end

   xsf_ram #(
      .WIDTH (DISPLAY_WIDTH),
      .DEPTH (DISPLAY_HEIGHT),
      .AW    (ROW_AW)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (old_row ^ mask),
      .rd_en   (accept),
      .rd_addr (addr_in),
      .rd_data (rd_row)
   );

   // sprite row to display mask, bit 7 leftmost, clipped at the right edge
   always_comb begin
      for (int c = 0; c < SPRITE_BITS; c++) begin
         rev_bits[c] = req_ff.sprite_byte[SPRITE_BITS-1-c];
      end
   end

   assign mask    = DISPLAY_WIDTH'(rev_bits) << req_ff.x_pos;
   assign old_row = (in_range_ff && valid_ff[addr_ff]) ? rd_row : '0;
   assign hit     = |(old_row & mask);
   assign wr_en   = exec && (req_ff.mode == MODE_DRAW) && in_range_ff;

   always_comb begin
      valid_in = valid_ff;
      seen_in  = seen_ff;
      rsp_data = '0;
      if (wr_en) begin
         valid_in[addr_ff] = 1'b1;
      end
      if (exec) begin
         unique case (req_ff.mode)
            MODE_DRAW: begin
               if (req_ff.last_row) begin
                  rsp_data.collision = seen_ff || hit;
                  seen_in            = 1'b0;
               end else begin
                  seen_in = seen_ff || hit;
               end
            end
            MODE_CLEAR: begin
               valid_in = '0;
            end
            MODE_READ: begin
               if (in_range_ff) begin
                  rsp_data.row_pixels = ROW_PIXELS_W'(old_row);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_strobe = exec;

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_data;
         addr_ff     <= addr_in;
         in_range_ff <= in_range_in;
      end
   end

   // every transfer gives one result in the next cycle
   a_rsp_after_transfer : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("no result after transfer");

   a_rsp_has_transfer : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept))
      else $error("result without transfer");

   a_collision_on_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.collision) |->
         (req_ff.mode == MODE_DRAW && req_ff.last_row))
      else $error("collision outside last draw row");

   a_pixels_on_read : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.row_pixels != '0)) |-> (req_ff.mode == MODE_READ))
      else $error("row pixels outside read");

   a_clear_drops_rows : assert property (@(posedge clock) disable iff (reset)
      (exec && req_ff.mode == MODE_CLEAR) |=> (valid_ff == '0))
      else $error("rows still valid after clear");

endmodule
